### src/eps_pkg.sv
// shared types and constants of the encoder position and speed block
`default_nettype none
package eps_pkg;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int REG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 15;
  localparam int SPD_W   = 20;
  localparam int DEN_W   = 48;
  localparam int MUL_AW  = 32;
  localparam int MUL_BW  = 20;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int NUM_W   = 68;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 72;

  localparam logic REG_PPR = 1'b0;
  localparam logic REG_IVL = 1'b1;

  localparam logic [REG_W-1:0]  PPR_RESET    = 16'd1024;
  localparam logic [REG_W-1:0]  IVL_RESET    = 16'd100;
  localparam logic [MUL_BW-1:0] RPM_Q4_SCALE = 20'd960000;
  localparam logic [MUL_BW-1:0] TWO_PI_Q12   = 20'd25736;
  localparam logic [SPD_W-1:0]  SPEED_MAX    = 20'h7FFFF;
  localparam logic [SPD_W-1:0]  SPEED_MIN    = 20'h80000;

  typedef struct packed {
    logic [REG_W-1:0] ppr;
    logic [REG_W-1:0] ivl;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### src/eps_regs.sv
// configuration registers behind the apb port
`default_nettype none
module eps_regs (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_psel,
  input  wire                       cfg_penable,
  input  wire                       cfg_pwrite,
  input  wire [eps_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire [eps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [eps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output eps_pkg::cfg_t             cfg
);
  import eps_pkg::*;

  logic [REG_W-1:0] ppr_r;
  logic [REG_W-1:0] ivl_r;
  logic             wr_en;
  logic             sel;

  assign cfg_pready = 1'b1;
  assign sel        = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= PPR_RESET;
      ivl_r <= IVL_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_PPR: ppr_r <= cfg_pwdata[REG_W-1:0];
        REG_IVL: ivl_r <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PPR: cfg_prdata = {{(CFG_DW-REG_W){1'b0}}, ppr_r};
      REG_IVL: cfg_prdata = {{(CFG_DW-REG_W){1'b0}}, ivl_r};
      default: cfg_prdata = '0;
    endcase
  end

  // zero behaves as one
  assign cfg.ppr = (ppr_r == '0) ? REG_W'(1) : ppr_r;
  assign cfg.ivl = (ivl_r == '0) ? REG_W'(1) : ivl_r;

endmodule
`default_nettype wire

### src/eps_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module eps_div #(
  parameter int SHW = 32,
  localparam int CW = $clog2(SHW + 1)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [eps_pkg::DEN_W-1:0] rem_init,
  input  wire [SHW-1:0]            sh_init,
  input  wire [eps_pkg::DEN_W-1:0] den,
  input  wire [CW-1:0]             steps,
  output eps_pkg::div_stat_t       stat,
  output logic [SHW-1:0]           quo,
  output logic [eps_pkg::DEN_W-1:0] rem
);
  import eps_pkg::*;

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [SHW-1:0]   sh_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, sh_r[SHW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      sh_r  <= sh_init;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_r  <= {sh_r[SHW-2:0], ge};
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quo       = sh_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

### src/encoder_position_speed.sv
// top level: encoder position count, angle and m-method speed
// Every beat, pulse or sample tick, ends by recomputing the angle within one
// turn from the current count and pulses per revolution: a modulo by pulses
// per revolution (COUNT_WIDTH divider steps) and a scaling division (15 steps).
// A tick that updates the speed first computes it: the denominator and then
// the two halves of the numerator are multiplied on the single 32 x 20
// multiplier, then the speed division yields 20 quotient bits, one per cycle;
// when the speed saturates, the division is skipped. All divisions run one
// bit a cycle on one shared restoring divider, and the input stays not ready
// while an item is in work. A finished result sits in an output register, so
// the next beat can be taken in the cycle after the result is loaded while it
// waits.
`default_nettype none
module encoder_position_speed #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // tdata: direction [0], sample_time_ms [32:1]
  input  wire [eps_pkg::IN_DW-1:0]  in_tdata,
  // tuser: action [0]
  input  wire                       in_tuser,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // tdata: position_count [31:0], angle_q12 [46:32], speed_rpm_q4 [66:47]
  output logic [eps_pkg::OUT_DW-1:0] out_tdata,
  // tuser: speed_updated [0]
  output logic                      out_tuser,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  input  wire                       cfg_psel,
  input  wire                       cfg_penable,
  input  wire                       cfg_pwrite,
  input  wire [eps_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire [eps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [eps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import eps_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > DEN_W) ? CW : DEN_W;
  localparam int SHW   = (CW > SPD_W) ? CW : SPD_W;
  localparam int DCW   = $clog2(SHW + 1);
  localparam int PW    = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MODGO = 12'b0000_0000_0010,
    S_MODW  = 12'b0000_0000_0100,
    S_AMUL  = 12'b0000_0000_1000,
    S_ADIV  = 12'b0000_0001_0000,
    S_ADIVW = 12'b0000_0010_0000,
    S_DEN   = 12'b0000_0100_0000,
    S_CHK   = 12'b0000_1000_0000,
    S_MHI   = 12'b0001_0000_0000,
    S_MADD  = 12'b0010_0000_0000,
    S_SDIVW = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t      cfg;
  div_stat_t div_stat;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     last_cnt_r;
  logic [TIME_W-1:0] last_time_r;
  logic [SPD_W-1:0]  speed_r;
  logic [ANG_W-1:0]  angle_r;
  logic [CW-1:0]     mag_r;
  logic              neg_r;
  logic [TIME_W-1:0] dt_r;
  logic              upd_r;
  logic [MUL_PW-1:0] mul_r;
  logic [MUL_PW-1:0] num_r;
  logic [DEN_W-1:0]  den_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_user_r;

  logic              accept;
  logic              in_action;
  logic              in_dir;
  logic [TIME_W-1:0] in_time;
  logic [CW-1:0]     diff;
  logic [CW-1:0]     diff_mag;
  logic [TIME_W-1:0] dt;
  logic              ivl_ok;
  logic              cnt_neg;
  logic [CW-1:0]     cnt_mag;
  logic [REG_W-1:0]  mod_r;
  logic [REG_W-1:0]  r_adj;
  logic [CMP_W-1:0]  magx;
  logic              ovf;
  logic [NUM_W-1:0]  nsum;
  logic [30:0]       na;
  logic [SPD_W-1:0]  q;
  logic [SPD_W-1:0]  speed_new;
  logic [PW-1:0]     cnt_ext;
  logic              out_free;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] prod;

  logic              div_start;
  logic [DEN_W-1:0]  div_rem_init;
  logic [SHW-1:0]    div_sh_init;
  logic [DEN_W-1:0]  div_den;
  logic [DCW-1:0]    div_steps;
  logic [SHW-1:0]    div_quo;
  logic [DEN_W-1:0]  div_rem;

  eps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  eps_div #(.SHW(SHW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .sh_init  (div_sh_init),
    .den      (div_den),
    .steps    (div_steps),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign in_action = in_tuser;
  assign in_dir    = in_tdata[0];
  assign in_time   = in_tdata[TIME_W:1];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  assign diff     = count_r - last_cnt_r;
  assign diff_mag = diff[CW-1] ? (~diff + CW'(1)) : diff;
  assign dt       = in_time - last_time_r;
  assign ivl_ok   = dt >= {{(TIME_W-REG_W){1'b0}}, cfg.ivl};

  assign cnt_neg = count_r[CW-1];
  assign cnt_mag = cnt_neg ? (~count_r + CW'(1)) : count_r;
  assign mod_r   = div_rem[REG_W-1:0];
  assign r_adj   = (cnt_neg && mod_r != '0) ? (cfg.ppr - mod_r) : mod_r;

  assign magx = CMP_W'(mag_r);
  assign ovf  = magx >= CMP_W'(mul_r[DEN_W-1:0]);
  assign nsum = NUM_W'(num_r) + {mul_r[NUM_W-POS_W-1:0], {POS_W{1'b0}}};
  assign na   = mul_r[30:0];

  // shared multiplier
  always_comb begin
    case (state_r)
      S_DEN: begin
        mul_a = dt_r;
        mul_b = MUL_BW'(cfg.ppr);
      end
      S_AMUL: begin
        mul_a = MUL_AW'(r_adj);
        mul_b = TWO_PI_Q12;
      end
      S_CHK: begin
        mul_a = magx[MUL_AW-1:0];
        mul_b = RPM_Q4_SCALE;
      end
      S_MHI: begin
        mul_a = MUL_AW'(magx[DEN_W-1:MUL_AW]);
        mul_b = RPM_Q4_SCALE;
      end
      default: begin
        mul_a = dt_r;
        mul_b = RPM_Q4_SCALE;
      end
    endcase
  end

  assign prod = MUL_PW'(mul_a) * MUL_PW'(mul_b);

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_sh_init  = SHW'(cnt_mag) << (SHW - CW);
    div_den      = DEN_W'(cfg.ppr);
    div_steps    = DCW'(CW);
    case (state_r)
      S_MODGO: begin
        div_start = 1'b1;
      end
      S_ADIV: begin
        div_start    = 1'b1;
        div_rem_init = DEN_W'(na[30:ANG_W]);
        div_sh_init  = SHW'(na[ANG_W-1:0]) << (SHW - ANG_W);
        div_steps    = DCW'(ANG_W);
      end
      S_MADD: begin
        div_start    = 1'b1;
        div_rem_init = nsum[NUM_W-1:SPD_W];
        div_sh_init  = SHW'(nsum[SPD_W-1:0]) << (SHW - SPD_W);
        div_den      = den_r;
        div_steps    = DCW'(SPD_W);
      end
      default: ;
    endcase
  end

  // saturate and apply sign
  assign q = div_quo[SPD_W-1:0];
  always_comb begin
    if (neg_r) speed_new = (q > SPEED_MIN) ? SPEED_MIN : (~q + SPD_W'(1));
    else       speed_new = (q > SPEED_MAX) ? SPEED_MAX : q;
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action && ivl_ok) state_nxt = S_DEN;
          else                     state_nxt = S_MODGO;
        end
      end
      S_MODGO: state_nxt = S_MODW;
      S_MODW:  if (div_stat.done) state_nxt = S_AMUL;
      S_AMUL:  state_nxt = S_ADIV;
      S_ADIV:  state_nxt = S_ADIVW;
      S_ADIVW: if (div_stat.done) state_nxt = S_OUT;
      S_DEN:   state_nxt = S_CHK;
      S_CHK:   state_nxt = ovf ? S_MODGO : S_MHI;
      S_MHI:   state_nxt = S_MADD;
      S_MADD:  state_nxt = S_SDIVW;
      S_SDIVW: if (div_stat.done) state_nxt = S_MODGO;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (state_r == S_OUT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      last_cnt_r  <= '0;
      last_time_r <= '0;
      speed_r     <= '0;
      angle_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (!in_action) begin
          count_r <= in_dir ? (count_r + CW'(1)) : (count_r - CW'(1));
        end else if (ivl_ok) begin
          last_cnt_r  <= count_r;
          last_time_r <= in_time;
        end
      end
      if (state_r == S_ADIVW && div_stat.done) angle_r <= div_quo[ANG_W-1:0];
      if (state_r == S_CHK && ovf) speed_r <= neg_r ? SPEED_MIN : SPEED_MAX;
      if (state_r == S_SDIVW && div_stat.done) speed_r <= speed_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd_r <= in_action & ivl_ok;
      mag_r <= diff_mag;
      neg_r <= diff[CW-1];
      dt_r  <= dt;
    end
    if (state_r == S_DEN || state_r == S_AMUL || state_r == S_CHK || state_r == S_MHI) begin
      mul_r <= prod;
    end
    if (state_r == S_CHK) den_r <= mul_r[DEN_W-1:0];
    if (state_r == S_MHI) num_r <= mul_r;
  end

  assign cnt_ext = PW'(count_r);

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {{(OUT_DW-POS_W-ANG_W-SPD_W){1'b0}}, speed_r, angle_r,
                     cnt_ext[POS_W-1:0]};
      out_user_r <= upd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("divider busy while input ready");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_MODW || state_r == S_ADIVW || state_r == S_SDIVW))
    else $error("divider finished outside a wait state");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[46:32] < 15'd25736))
    else $error("angle beyond one turn");

  a_pulse_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_action) |=> !upd_r)
    else $error("pulse beat flagged as speed update");

endmodule
`default_nettype wire

### tb/encoder_position_speed_tb.sv
// testbench for encoder_position_speed: directed rows, random pulse and tick runs, predictor check
`default_nettype none
module encoder_position_speed_tb;

  localparam logic ACT_PULSE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;
  localparam logic DIR_DOWN  = 1'b0;
  localparam logic DIR_UP    = 1'b1;

  localparam logic [63:0] TURN_Q12    = 64'd25736;
  localparam logic [63:0] RPM_Q4_MS   = 64'd960000;
  localparam logic [63:0] SPD_POS_LIM = 64'd524287;
  localparam logic [63:0] SPD_NEG_LIM = 64'd524288;

  typedef struct packed {
    logic [31:0] pos;
    logic [14:0] angle;
    logic [19:0] speed;
    logic        updated;
  } position_speed_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic            sel;
    logic [15:0]     value;
    logic            act;
    logic            dir;
    logic [31:0]     stamp;
    logic            typed;
    position_speed_t res;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic [eps_pkg::IN_DW-1:0]   in_tdata;   // direction [0], sample_time_ms [32:1]
  logic                        in_tuser;   // action [0]
  logic                        in_tvalid;
  logic                        in_tready;
  logic [eps_pkg::OUT_DW-1:0]  out_tdata;  // position_count [31:0], angle_q12 [46:32],
                                           // speed_rpm_q4 [66:47]
  logic                        out_tuser;  // speed_updated [0]
  logic                        out_tvalid;
  logic                        out_tready;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [eps_pkg::CFG_AW-1:0]  cfg_paddr;
  logic [eps_pkg::CFG_DW-1:0]  cfg_pwdata;
  logic [eps_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  encoder_position_speed dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state
  logic [15:0] ppr_reg;
  logic [15:0] ivl_reg;
  logic [31:0] pos_count;
  logic [31:0] ref_count;
  logic [31:0] ref_stamp;
  logic [19:0] speed_q4;

  position_speed_t pending_readings[$];
  stim_row_t       directed_rows[$];
  int              mismatches;
  bit              sender_calm;
  logic [31:0]     sample_clock;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic position_speed_t advance_encoder(logic act, logic dir, logic [31:0] stamp);
    position_speed_t r;
    logic [31:0] dt, ivl_eff, diff, mag, pmag;
    logic [63:0] ppr_eff, rem, den, q, ang;
    r.updated = 1'b0;
    ppr_eff = (ppr_reg == 16'd0) ? 64'd1 : {48'd0, ppr_reg};
    if (act == ACT_PULSE) begin
      pos_count = (dir == DIR_UP) ? pos_count + 32'd1 : pos_count - 32'd1;
    end else begin
      dt = stamp - ref_stamp;
      ivl_eff = (ivl_reg == 16'd0) ? 32'd1 : {16'd0, ivl_reg};
      if (dt >= ivl_eff) begin
        diff = pos_count - ref_count;
        mag = diff[31] ? (~diff + 32'd1) : diff;
        den = ppr_eff * {32'd0, dt};
        q = ({32'd0, mag} * RPM_Q4_MS) / den;
        if (diff[31]) begin
          if (q > SPD_NEG_LIM) q = SPD_NEG_LIM;
          speed_q4 = 20'd0 - q[19:0];
        end else begin
          if (q > SPD_POS_LIM) q = SPD_POS_LIM;
          speed_q4 = q[19:0];
        end
        ref_count = pos_count;
        ref_stamp = stamp;
        r.updated = 1'b1;
      end
    end
    // angle from the count taken modulo one turn, non-negative
    pmag = pos_count[31] ? (~pos_count + 32'd1) : pos_count;
    rem = {32'd0, pmag} % ppr_eff;
    if (pos_count[31] && rem != 64'd0) rem = ppr_eff - rem;
    ang = (rem * TURN_Q12) / ppr_eff;
    r.pos = pos_count;
    r.angle = ang[14:0];
    r.speed = speed_q4;
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endfunction

  always @(posedge clk) begin : result_check
    position_speed_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pos = out_tdata[31:0];
      got.angle = out_tdata[46:32];
      got.speed = out_tdata[66:47];
      got.updated = out_tuser;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: position_count %0h", got.pos);
      end else begin
        want = pending_readings.pop_front();
        if (got.pos !== want.pos) note_mismatch("position_count", want.pos, got.pos);
        if (got.angle !== want.angle) note_mismatch("angle_q12", want.angle, got.angle);
        if (got.speed !== want.speed) note_mismatch("speed_rpm_q4", want.speed, got.speed);
        if (got.updated !== want.updated)
          note_mismatch("speed_updated", want.updated, got.updated);
      end
    end
  end

  // result side backpressure: ready runs and stalls of random length
  initial begin : result_stall
    int run_len, stall_len;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run_len) @(posedge clk);
      case ($urandom_range(0, 19))
        0:       stall_len = $urandom_range(20, 60);
        1, 2, 3: stall_len = 0;
        default: stall_len = $urandom_range(1, 3);
      endcase
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (sender_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(20, 60);
    if (roll < 45) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_item(input logic act, input logic dir, input logic [31:0] stamp,
                           input logic typed, input position_speed_t typed_res);
    int gap;
    position_speed_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'd0, stamp, dir};
    do @(posedge clk); while (!in_tready);
    res = advance_encoder(act, dir, stamp);
    pending_readings.push_back(typed ? typed_res : res);
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [15:0] value);
    logic [31:0] rd;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == eps_pkg::REG_PPR) ppr_reg = value;
    else ivl_reg = value;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd !== {16'd0, value}) note_mismatch("register read", {16'd0, value}, rd);
  endtask

  function automatic stim_row_t item_row(logic act, logic dir, logic [31:0] stamp);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.act = act;
    row.dir = dir;
    row.stamp = stamp;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic act, logic dir, logic [31:0] stamp,
                                          logic [31:0] pos, logic [14:0] angle,
                                          logic [19:0] speed, logic updated);
    stim_row_t row;
    row = item_row(act, dir, stamp);
    row.typed = 1'b1;
    row.res.pos = pos;
    row.res.angle = angle;
    row.res.speed = speed;
    row.res.updated = updated;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic sel, logic [15:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.sel = sel;
    row.value = value;
    return row;
  endfunction

  task automatic load_directed();
    // reset settings: 1024 counts per turn, 100 ms interval
    directed_rows.push_back(typed_row(ACT_PULSE, DIR_DOWN, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 15'd25710, 20'd0, 1'b0));
    directed_rows.push_back(typed_row(ACT_PULSE, DIR_UP, 32'h0, 32'd0, 15'd0, 20'd0, 1'b0));
    directed_rows.push_back(typed_row(ACT_TICK, DIR_UP, 32'd99, 32'd0, 15'd0, 20'd0, 1'b0));
    directed_rows.push_back(typed_row(ACT_TICK, DIR_DOWN, 32'd100, 32'd0, 15'd0, 20'd0, 1'b1));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_UP, 32'hA5A5_5A5A));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_UP, 32'h5A5A_A5A5));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_UP, 32'h1234_5678));
    directed_rows.push_back(item_row(ACT_TICK, DIR_UP, 32'd150));
    directed_rows.push_back(item_row(ACT_TICK, DIR_DOWN, 32'd200));
    // one count per turn, 1 ms interval: speed saturates both ways
    directed_rows.push_back(cfg_row(eps_pkg::REG_PPR, 16'd1));
    directed_rows.push_back(cfg_row(eps_pkg::REG_IVL, 16'd1));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_UP, 32'h0));
    directed_rows.push_back(typed_row(ACT_TICK, DIR_UP, 32'd201,
                                      32'd4, 15'd0, 20'h7FFFF, 1'b1));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_DOWN, 32'hFFFF_0000));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_DOWN, 32'h0000_FFFF));
    directed_rows.push_back(typed_row(ACT_TICK, DIR_DOWN, 32'd202,
                                      32'd2, 15'd0, 20'h80000, 1'b1));
    // time wrap
    directed_rows.push_back(typed_row(ACT_TICK, DIR_UP, 32'hFFFF_FFFF,
                                      32'd2, 15'd0, 20'd0, 1'b1));
    directed_rows.push_back(item_row(ACT_TICK, DIR_UP, 32'd3));
    // zero registers act as one
    directed_rows.push_back(cfg_row(eps_pkg::REG_PPR, 16'd0));
    directed_rows.push_back(cfg_row(eps_pkg::REG_IVL, 16'd0));
    directed_rows.push_back(typed_row(ACT_PULSE, DIR_DOWN, 32'h8000_0001,
                                      32'd1, 15'd0, 20'd0, 1'b0));
    directed_rows.push_back(typed_row(ACT_TICK, DIR_UP, 32'd3, 32'd1, 15'd0, 20'd0, 1'b0));
    directed_rows.push_back(item_row(ACT_TICK, DIR_DOWN, 32'd4));
    // largest settings, angle just below a full turn
    directed_rows.push_back(cfg_row(eps_pkg::REG_PPR, 16'hFFFF));
    directed_rows.push_back(cfg_row(eps_pkg::REG_IVL, 16'hFFFF));
    directed_rows.push_back(item_row(ACT_PULSE, DIR_DOWN, 32'h7FFF_FFFF));
    directed_rows.push_back(typed_row(ACT_PULSE, DIR_DOWN, 32'h0,
                                      32'hFFFF_FFFF, 15'd25735, 20'h80000, 1'b0));
    directed_rows.push_back(item_row(ACT_TICK, DIR_UP, 32'd65538));
    directed_rows.push_back(item_row(ACT_TICK, DIR_UP, 32'd65539));
  endtask

  task automatic run_phase(input logic [15:0] ppr, input logic [15:0] ivl, input int items);
    int sent, burst, k;
    logic lean_up;
    int unsigned span;
    release_input();
    wait_drained();
    write_register(eps_pkg::REG_PPR, ppr);
    write_register(eps_pkg::REG_IVL, ivl);
    span = (ivl == 16'd0) ? 1 : ivl;
    sent = 0;
    while (sent < items) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      lean_up = $urandom_range(0, 1);
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 12);
      for (k = 0; k < burst; k++) begin
        send_item(ACT_PULSE, ($urandom_range(0, 9) < 8) ? lean_up : !lean_up,
                  $urandom, 1'b0, '0);
        sent++;
      end
      case ($urandom_range(0, 19))
        0:       sample_clock = $urandom;
        1, 2:    sample_clock = sample_clock + $urandom_range(0, span - 1);
        default: sample_clock = sample_clock + $urandom_range(0, 2 * span);
      endcase
      send_item(ACT_TICK, $urandom_range(0, 1), sample_clock, 1'b0, '0);
      sent++;
      if ($urandom_range(0, 99) == 0) begin
        release_input();
        wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    ppr_reg = 16'd1024;
    ivl_reg = 16'd100;
    pos_count = '0;
    ref_count = '0;
    ref_stamp = '0;
    speed_q4 = '0;
    mismatches = 0;
    sender_calm = 1'b0;
    sample_clock = 32'd65539;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_directed();
    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        release_input();
        wait_drained();
        write_register(directed_rows[i].sel, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].act, directed_rows[i].dir, directed_rows[i].stamp,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    run_phase(16'd1024, 16'd100, 240);
    run_phase(16'd1, 16'd1, 240);
    run_phase(16'hFFFF, 16'hFFFF, 240);
    run_phase(16'd360, 16'd10, 230);
    for (i = 0; i < 4; i++)
      run_phase(($urandom_range(0, 1) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 65535),
                $urandom_range(1, 2000), 230);

    release_input();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
